@@ rtl/dpq_pkg.sv @@
// Shared types and constants for the DAG path query engine.
package dpq_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int MAX_EDGES    = 4096;

    localparam int VID_W  = $clog2(MAX_VERTICES);     // vertex id
    localparam int VCNT_W = $clog2(MAX_VERTICES + 1); // vertex count
    localparam int EID_W  = $clog2(MAX_EDGES);        // edge slot
    localparam int ECNT_W = $clog2(MAX_EDGES + 1);    // edge count
    localparam int LNG_W  = VCNT_W;                   // longest length plus marker
    localparam int CNT_W  = 30;

    localparam logic [CNT_W-1:0] PATH_MODULUS = 30'd1000000007;
    localparam logic [LNG_W-1:0] LNG_NONE     = '1;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_QUERY = 2'd1,
        OP_CLEAR = 2'd2
    } opcode_t;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [VID_W-1:0] from_vertex;
        logic [VID_W-1:0] to_vertex;
    } dpq_req_t;

    typedef struct packed {
        logic [VID_W-1:0] shortest_length;
        logic [VID_W-1:0] longest_length;
        logic [CNT_W-1:0] path_count;
        logic             reachable;
        logic             not_acyclic;
        logic             edges_dropped;
    } dpq_res_t;

endpackage

@@ rtl/dpq_modadd.sv @@
// Modular adder: (a + b) mod 1000000007 for operands already reduced.
module dpq_modadd (
    input  logic [dpq_pkg::CNT_W-1:0] addend_a,
    input  logic [dpq_pkg::CNT_W-1:0] addend_b,
    output logic [dpq_pkg::CNT_W-1:0] sum
);
    import dpq_pkg::*;

    logic [CNT_W:0] raw;

    always_comb begin
        raw = {1'b0, addend_a} + {1'b0, addend_b};
        if (raw >= {1'b0, PATH_MODULUS}) begin
            raw = raw - {1'b0, PATH_MODULUS};
        end
        sum = raw[CNT_W-1:0];
    end
endmodule

@@ rtl/dag_path_query_engine_unit.sv @@
// Top level: edge store, query sequencer and scratch memories of the DAG path query engine.
//
//  channel | ports                         | payload
//  --------+-------------------------------+------------------------------------------
//  request | s_valid  s_ready  s_data      | dpq_req_t: opcode, from_vertex, to_vertex
//  result  | m_valid  m_ready  m_data      | dpq_res_t: lengths, path count, flags
//  config  | cfg_valid cfg_ready cfg_data  | vertex_count, 11 bits, reset 1024
//
// Add edge, clear graph and unused opcodes complete in the idle state. A path query runs
// a sequencer over scratch memories that each have one write and one registered read
// port; it makes edge passes for degree count, row scatter, BFS and Kahn order with
// the DP fold.
// No clearing pass after reset; each query sweeps its scratch rows first.
// s_ready is low for the whole query; a result waits in m_data until taken.
module dag_path_query_engine_unit (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  dpq_pkg::dpq_req_t          s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output dpq_pkg::dpq_res_t          m_data,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [dpq_pkg::VCNT_W-1:0] cfg_data
);
    import dpq_pkg::*;

    typedef enum logic [29:0] {
        ST_IDLE     = 30'h0000_0001,
        ST_CLR      = 30'h0000_0002,
        ST_CNT_RD   = 30'h0000_0004,
        ST_CNT_CHK  = 30'h0000_0008,
        ST_CNT_UPD  = 30'h0000_0010,
        ST_PFX_RD   = 30'h0000_0020,
        ST_PFX_WR   = 30'h0000_0040,
        ST_SCT_RD   = 30'h0000_0080,
        ST_SCT_CHK  = 30'h0000_0100,
        ST_SCT_WR   = 30'h0000_0200,
        ST_BFS_INIT = 30'h0000_0400,
        ST_BFS_POP  = 30'h0000_0800,
        ST_BFS_ROW  = 30'h0000_1000,
        ST_BFS_HOP  = 30'h0000_2000,
        ST_BFS_EDGE = 30'h0000_4000,
        ST_BFS_SEEN = 30'h0000_8000,
        ST_BFS_VIS  = 30'h0001_0000,
        ST_BFS_DST  = 30'h0002_0000,
        ST_BFS_RES  = 30'h0004_0000,
        ST_TOP_SCAN = 30'h0008_0000,
        ST_TOP_ZERO = 30'h0010_0000,
        ST_TOP_POP  = 30'h0020_0000,
        ST_TOP_ROW  = 30'h0040_0000,
        ST_TOP_HOP  = 30'h0080_0000,
        ST_TOP_EDGE = 30'h0100_0000,
        ST_TOP_NB   = 30'h0200_0000,
        ST_TOP_UPD  = 30'h0400_0000,
        ST_FIN_RD   = 30'h0800_0000,
        ST_FIN      = 30'h1000_0000,
        ST_OUT      = 30'h2000_0000
    } state_t;

    // control
    state_t              state_reg, state_next;
    logic [VCNT_W-1:0]   vcount_reg, vcount_next;
    logic [ECNT_W-1:0]   etotal_reg, etotal_next;
    logic                sticky_reg, sticky_next;
    logic                m_valid_reg, m_valid_next;

    // sequencer working registers
    logic [ECNT_W-1:0]   idx_reg, idx_next;
    logic [VCNT_W-1:0]   head_reg, head_next;
    logic [VCNT_W-1:0]   tail_reg, tail_next;
    logic [ECNT_W-1:0]   k_reg, k_next;
    logic [ECNT_W-1:0]   end_reg, end_next;
    logic [ECNT_W-1:0]   acc_reg, acc_next;
    logic [VID_W-1:0]    src_reg, src_next;
    logic [VID_W-1:0]    dst_reg, dst_next;
    logic [VID_W-1:0]    t_reg, t_next;
    logic [VID_W-1:0]    h_reg, h_next;
    logic [VID_W-1:0]    b_reg, b_next;
    logic [VID_W-1:0]    hopa_reg, hopa_next;
    logic [LNG_W-1:0]    la_reg, la_next;
    logic [CNT_W-1:0]    wa_reg, wa_next;
    logic                reach_reg, reach_next;
    logic [VID_W-1:0]    short_reg, short_next;
    logic                cyc_reg, cyc_next;
    dpq_res_t            res_reg, res_next;
    dpq_res_t            m_data_reg, m_data_next;

    logic [VCNT_W-1:0]   n_active;
    logic [CNT_W-1:0]    ways_sum;
    logic [LNG_W-1:0]    cand;

    // memories: one write and one registered read port each
    logic [VID_W-1:0]  et_mem   [MAX_EDGES];
    logic [VID_W-1:0]  eh_mem   [MAX_EDGES];
    logic [VID_W-1:0]  rh_mem   [MAX_EDGES];
    logic [ECNT_W-1:0] rb_mem   [MAX_VERTICES];
    logic [ECNT_W-1:0] rf_mem   [MAX_VERTICES];
    logic [ECNT_W-1:0] deg_mem  [MAX_VERTICES];
    logic              seen_mem [MAX_VERTICES];
    logic [VID_W-1:0]  hop_mem  [MAX_VERTICES];
    logic [LNG_W-1:0]  lng_mem  [MAX_VERTICES];
    logic [CNT_W-1:0]  ways_mem [MAX_VERTICES];
    logic [VID_W-1:0]  q_mem    [MAX_VERTICES];

    logic [VID_W-1:0]  et_rd_reg, eh_rd_reg, rh_rd_reg, hop_rd_reg, q_rd_reg;
    logic [ECNT_W-1:0] rb_rd_reg, rf_rd_reg, deg_rd_reg;
    logic              seen_rd_reg;
    logic [LNG_W-1:0]  lng_rd_reg;
    logic [CNT_W-1:0]  ways_rd_reg;

    logic              e_we;
    logic [EID_W-1:0]  e_wa, e_ra;
    logic              rh_we;
    logic [EID_W-1:0]  rh_wa, rh_ra;
    logic [VID_W-1:0]  rh_wd;
    logic              rb_we, rf_we, deg_we, seen_we, hop_we, lng_we, ways_we, q_we;
    logic [VID_W-1:0]  rb_wa, rf_wa, deg_wa, seen_wa, hop_wa, lng_wa, ways_wa, q_wa;
    logic [VID_W-1:0]  rb_ra, rf_ra, deg_ra, seen_ra, hop_ra, lng_ra, ways_ra, q_ra;
    logic [ECNT_W-1:0] rb_wd, rf_wd, deg_wd;
    logic              seen_wd;
    logic [VID_W-1:0]  hop_wd, q_wd;
    logic [LNG_W-1:0]  lng_wd;
    logic [CNT_W-1:0]  ways_wd;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // effective vertex count: register clipped to the store size
    assign n_active = (vcount_reg > VCNT_W'(MAX_VERTICES)) ? VCNT_W'(MAX_VERTICES)
                                                            : vcount_reg;

    dpq_modadd u_modadd (
        .addend_a (wa_reg),
        .addend_b (ways_rd_reg),
        .sum      (ways_sum)
    );

    assign cand = la_reg + LNG_W'(1);

    always_comb begin
        state_next   = state_reg;
        vcount_next  = vcount_reg;
        etotal_next  = etotal_reg;
        sticky_next  = sticky_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        idx_next     = idx_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        k_next       = k_reg;
        end_next     = end_reg;
        acc_next     = acc_reg;
        src_next     = src_reg;
        dst_next     = dst_reg;
        t_next       = t_reg;
        h_next       = h_reg;
        b_next       = b_reg;
        hopa_next    = hopa_reg;
        la_next      = la_reg;
        wa_next      = wa_reg;
        reach_next   = reach_reg;
        short_next   = short_reg;
        cyc_next     = cyc_reg;
        res_next     = res_reg;

        e_we = 1'b0;  e_wa = '0;  e_ra = '0;
        rh_we = 1'b0; rh_wa = '0; rh_ra = '0; rh_wd = '0;
        rb_we = 1'b0; rb_wa = '0; rb_ra = '0; rb_wd = '0;
        rf_we = 1'b0; rf_wa = '0; rf_ra = '0; rf_wd = '0;
        deg_we = 1'b0; deg_wa = '0; deg_ra = '0; deg_wd = '0;
        seen_we = 1'b0; seen_wa = '0; seen_ra = '0; seen_wd = 1'b0;
        hop_we = 1'b0; hop_wa = '0; hop_ra = '0; hop_wd = '0;
        lng_we = 1'b0; lng_wa = '0; lng_ra = '0; lng_wd = '0;
        ways_we = 1'b0; ways_wa = '0; ways_ra = '0; ways_wd = '0;
        q_we = 1'b0; q_wa = '0; q_ra = '0; q_wd = '0;

        if (cfg_valid) begin
            vcount_next = cfg_data;
        end
        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_data.opcode)
                        OP_ADD: begin
                            if (etotal_reg >= ECNT_W'(MAX_EDGES)
                                || {1'b0, s_data.from_vertex} >= n_active
                                || {1'b0, s_data.to_vertex} >= n_active) begin
                                sticky_next = 1'b1;
                            end else begin
                                e_we        = 1'b1;
                                e_wa        = etotal_reg[EID_W-1:0];
                                etotal_next = etotal_reg + ECNT_W'(1);
                            end
                        end
                        OP_QUERY: begin
                            src_next = s_data.from_vertex;
                            dst_next = s_data.to_vertex;
                            if ({1'b0, s_data.from_vertex} < n_active
                                && {1'b0, s_data.to_vertex} < n_active) begin
                                idx_next   = '0;
                                acc_next   = '0;
                                state_next = ST_CLR;
                            end else begin
                                res_next               = '0;
                                res_next.edges_dropped = sticky_reg;
                                state_next             = ST_OUT;
                            end
                        end
                        OP_CLEAR: begin
                            etotal_next = '0;
                            sticky_next = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            // sweep scratch rows; seed the source in the DP stores
            ST_CLR: begin
                if (idx_reg < ECNT_W'(n_active)) begin
                    rf_we = 1'b1;  rf_wa = idx_reg[VID_W-1:0];
                    deg_we = 1'b1; deg_wa = idx_reg[VID_W-1:0];
                    seen_we = 1'b1; seen_wa = idx_reg[VID_W-1:0];
                    lng_we = 1'b1; lng_wa = idx_reg[VID_W-1:0];
                    ways_we = 1'b1; ways_wa = idx_reg[VID_W-1:0];
                    if (idx_reg[VID_W-1:0] == src_reg) begin
                        lng_wd  = '0;
                        ways_wd = CNT_W'(1);
                    end else begin
                        lng_wd  = LNG_NONE;
                    end
                    idx_next = idx_reg + ECNT_W'(1);
                end else begin
                    idx_next   = '0;
                    state_next = ST_CNT_RD;
                end
            end
            // out-degree and in-degree count
            ST_CNT_RD: begin
                if (idx_reg < etotal_reg) begin
                    e_ra       = idx_reg[EID_W-1:0];
                    state_next = ST_CNT_CHK;
                end else begin
                    idx_next   = '0;
                    state_next = ST_PFX_RD;
                end
            end
            ST_CNT_CHK: begin
                if ({1'b0, et_rd_reg} < n_active && {1'b0, eh_rd_reg} < n_active) begin
                    rf_ra      = et_rd_reg;
                    deg_ra     = eh_rd_reg;
                    t_next     = et_rd_reg;
                    h_next     = eh_rd_reg;
                    state_next = ST_CNT_UPD;
                end else begin
                    idx_next   = idx_reg + ECNT_W'(1);
                    state_next = ST_CNT_RD;
                end
            end
            ST_CNT_UPD: begin
                rf_we      = 1'b1; rf_wa = t_reg; rf_wd = rf_rd_reg + ECNT_W'(1);
                deg_we     = 1'b1; deg_wa = h_reg; deg_wd = deg_rd_reg + ECNT_W'(1);
                idx_next   = idx_reg + ECNT_W'(1);
                state_next = ST_CNT_RD;
            end
            // exclusive prefix: rb holds row start, rf becomes the fill pointer
            ST_PFX_RD: begin
                if (idx_reg < ECNT_W'(n_active)) begin
                    rf_ra      = idx_reg[VID_W-1:0];
                    state_next = ST_PFX_WR;
                end else begin
                    idx_next   = '0;
                    state_next = ST_SCT_RD;
                end
            end
            ST_PFX_WR: begin
                rb_we      = 1'b1; rb_wa = idx_reg[VID_W-1:0]; rb_wd = acc_reg;
                rf_we      = 1'b1; rf_wa = idx_reg[VID_W-1:0]; rf_wd = acc_reg;
                acc_next   = acc_reg + rf_rd_reg;
                idx_next   = idx_reg + ECNT_W'(1);
                state_next = ST_PFX_RD;
            end
            // scatter heads into rows; afterwards rf holds row end
            ST_SCT_RD: begin
                if (idx_reg < etotal_reg) begin
                    e_ra       = idx_reg[EID_W-1:0];
                    state_next = ST_SCT_CHK;
                end else begin
                    state_next = ST_BFS_INIT;
                end
            end
            ST_SCT_CHK: begin
                if ({1'b0, et_rd_reg} < n_active && {1'b0, eh_rd_reg} < n_active) begin
                    rf_ra      = et_rd_reg;
                    t_next     = et_rd_reg;
                    h_next     = eh_rd_reg;
                    state_next = ST_SCT_WR;
                end else begin
                    idx_next   = idx_reg + ECNT_W'(1);
                    state_next = ST_SCT_RD;
                end
            end
            ST_SCT_WR: begin
                rh_we      = 1'b1; rh_wa = rf_rd_reg[EID_W-1:0]; rh_wd = h_reg;
                rf_we      = 1'b1; rf_wa = t_reg; rf_wd = rf_rd_reg + ECNT_W'(1);
                idx_next   = idx_reg + ECNT_W'(1);
                state_next = ST_SCT_RD;
            end
            // breadth-first search from the source
            ST_BFS_INIT: begin
                seen_we    = 1'b1; seen_wa = src_reg; seen_wd = 1'b1;
                hop_we     = 1'b1; hop_wa = src_reg;
                q_we       = 1'b1; q_wd = src_reg;
                head_next  = '0;
                tail_next  = VCNT_W'(1);
                state_next = ST_BFS_POP;
            end
            ST_BFS_POP: begin
                if (head_reg < tail_reg) begin
                    q_ra       = head_reg[VID_W-1:0];
                    state_next = ST_BFS_ROW;
                end else begin
                    state_next = ST_BFS_DST;
                end
            end
            ST_BFS_ROW: begin
                rb_ra      = q_rd_reg;
                rf_ra      = q_rd_reg;
                hop_ra     = q_rd_reg;
                head_next  = head_reg + VCNT_W'(1);
                state_next = ST_BFS_HOP;
            end
            ST_BFS_HOP: begin
                k_next     = rb_rd_reg;
                end_next   = rf_rd_reg;
                hopa_next  = hop_rd_reg;
                state_next = ST_BFS_EDGE;
            end
            ST_BFS_EDGE: begin
                if (k_reg < end_reg) begin
                    rh_ra      = k_reg[EID_W-1:0];
                    state_next = ST_BFS_SEEN;
                end else begin
                    state_next = ST_BFS_POP;
                end
            end
            ST_BFS_SEEN: begin
                seen_ra    = rh_rd_reg;
                b_next     = rh_rd_reg;
                state_next = ST_BFS_VIS;
            end
            ST_BFS_VIS: begin
                if (!seen_rd_reg) begin
                    seen_we   = 1'b1; seen_wa = b_reg; seen_wd = 1'b1;
                    hop_we    = 1'b1; hop_wa = b_reg; hop_wd = hopa_reg + VID_W'(1);
                    q_we      = 1'b1; q_wa = tail_reg[VID_W-1:0]; q_wd = b_reg;
                    tail_next = tail_reg + VCNT_W'(1);
                end
                k_next     = k_reg + ECNT_W'(1);
                state_next = ST_BFS_EDGE;
            end
            ST_BFS_DST: begin
                seen_ra    = dst_reg;
                hop_ra     = dst_reg;
                state_next = ST_BFS_RES;
            end
            ST_BFS_RES: begin
                reach_next = seen_rd_reg;
                short_next = seen_rd_reg ? hop_rd_reg : '0;
                idx_next   = '0;
                tail_next  = '0;
                state_next = ST_TOP_SCAN;
            end
            // Kahn order; longest length and path count fold in as rows pop
            ST_TOP_SCAN: begin
                if (idx_reg < ECNT_W'(n_active)) begin
                    deg_ra     = idx_reg[VID_W-1:0];
                    state_next = ST_TOP_ZERO;
                end else begin
                    head_next  = '0;
                    state_next = ST_TOP_POP;
                end
            end
            ST_TOP_ZERO: begin
                if (deg_rd_reg == '0) begin
                    q_we      = 1'b1; q_wa = tail_reg[VID_W-1:0]; q_wd = idx_reg[VID_W-1:0];
                    tail_next = tail_reg + VCNT_W'(1);
                end
                idx_next   = idx_reg + ECNT_W'(1);
                state_next = ST_TOP_SCAN;
            end
            ST_TOP_POP: begin
                if (head_reg < tail_reg) begin
                    q_ra       = head_reg[VID_W-1:0];
                    state_next = ST_TOP_ROW;
                end else begin
                    state_next = ST_FIN_RD;
                end
            end
            ST_TOP_ROW: begin
                rb_ra      = q_rd_reg;
                rf_ra      = q_rd_reg;
                lng_ra     = q_rd_reg;
                ways_ra    = q_rd_reg;
                head_next  = head_reg + VCNT_W'(1);
                state_next = ST_TOP_HOP;
            end
            ST_TOP_HOP: begin
                k_next     = rb_rd_reg;
                end_next   = rf_rd_reg;
                la_next    = lng_rd_reg;
                wa_next    = ways_rd_reg;
                state_next = ST_TOP_EDGE;
            end
            ST_TOP_EDGE: begin
                if (k_reg < end_reg) begin
                    rh_ra      = k_reg[EID_W-1:0];
                    state_next = ST_TOP_NB;
                end else begin
                    state_next = ST_TOP_POP;
                end
            end
            ST_TOP_NB: begin
                deg_ra     = rh_rd_reg;
                lng_ra     = rh_rd_reg;
                ways_ra    = rh_rd_reg;
                b_next     = rh_rd_reg;
                state_next = ST_TOP_UPD;
            end
            ST_TOP_UPD: begin
                deg_we = 1'b1; deg_wa = b_reg; deg_wd = deg_rd_reg - ECNT_W'(1);
                if (deg_rd_reg == ECNT_W'(1)) begin
                    q_we      = 1'b1; q_wa = tail_reg[VID_W-1:0]; q_wd = b_reg;
                    tail_next = tail_reg + VCNT_W'(1);
                end
                // unreached tails never propagate
                if (la_reg != LNG_NONE) begin
                    lng_we  = 1'b1; lng_wa = b_reg;
                    lng_wd  = (lng_rd_reg == LNG_NONE || lng_rd_reg < cand) ? cand
                                                                             : lng_rd_reg;
                    ways_we = 1'b1; ways_wa = b_reg; ways_wd = ways_sum;
                end
                k_next     = k_reg + ECNT_W'(1);
                state_next = ST_TOP_EDGE;
            end
            ST_FIN_RD: begin
                lng_ra     = dst_reg;
                ways_ra    = dst_reg;
                cyc_next   = (head_reg < n_active);
                state_next = ST_FIN;
            end
            ST_FIN: begin
                res_next                 = '0;
                res_next.shortest_length = short_reg;
                res_next.reachable       = reach_reg;
                res_next.not_acyclic     = cyc_reg;
                res_next.edges_dropped   = sticky_reg;
                if (!cyc_reg && reach_reg) begin
                    res_next.longest_length = lng_rd_reg[VID_W-1:0];
                    res_next.path_count     = ways_rd_reg;
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            vcount_reg  <= VCNT_W'(MAX_VERTICES);
            etotal_reg  <= '0;
            sticky_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            vcount_reg  <= vcount_next;
            etotal_reg  <= etotal_next;
            sticky_reg  <= sticky_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        head_reg   <= head_next;
        tail_reg   <= tail_next;
        k_reg      <= k_next;
        end_reg    <= end_next;
        acc_reg    <= acc_next;
        src_reg    <= src_next;
        dst_reg    <= dst_next;
        t_reg      <= t_next;
        h_reg      <= h_next;
        b_reg      <= b_next;
        hopa_reg   <= hopa_next;
        la_reg     <= la_next;
        wa_reg     <= wa_next;
        reach_reg  <= reach_next;
        short_reg  <= short_next;
        cyc_reg    <= cyc_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    // edge store
    always_ff @(posedge aclk) begin
        if (e_we) begin
            et_mem[e_wa] <= s_data.from_vertex;
            eh_mem[e_wa] <= s_data.to_vertex;
        end
        et_rd_reg <= et_mem[e_ra];
        eh_rd_reg <= eh_mem[e_ra];
    end

    // row heads
    always_ff @(posedge aclk) begin
        if (rh_we) begin
            rh_mem[rh_wa] <= rh_wd;
        end
        rh_rd_reg <= rh_mem[rh_ra];
    end

    // per-vertex scratch
    always_ff @(posedge aclk) begin
        if (rb_we) begin
            rb_mem[rb_wa] <= rb_wd;
        end
        rb_rd_reg <= rb_mem[rb_ra];
    end

    always_ff @(posedge aclk) begin
        if (rf_we) begin
            rf_mem[rf_wa] <= rf_wd;
        end
        rf_rd_reg <= rf_mem[rf_ra];
    end

    always_ff @(posedge aclk) begin
        if (deg_we) begin
            deg_mem[deg_wa] <= deg_wd;
        end
        deg_rd_reg <= deg_mem[deg_ra];
    end

    always_ff @(posedge aclk) begin
        if (seen_we) begin
            seen_mem[seen_wa] <= seen_wd;
        end
        seen_rd_reg <= seen_mem[seen_ra];
    end

    always_ff @(posedge aclk) begin
        if (hop_we) begin
            hop_mem[hop_wa] <= hop_wd;
        end
        hop_rd_reg <= hop_mem[hop_ra];
    end

    always_ff @(posedge aclk) begin
        if (lng_we) begin
            lng_mem[lng_wa] <= lng_wd;
        end
        lng_rd_reg <= lng_mem[lng_ra];
    end

    always_ff @(posedge aclk) begin
        if (ways_we) begin
            ways_mem[ways_wa] <= ways_wd;
        end
        ways_rd_reg <= ways_mem[ways_ra];
    end

    always_ff @(posedge aclk) begin
        if (q_we) begin
            q_mem[q_wa] <= q_wd;
        end
        q_rd_reg <= q_mem[q_ra];
    end

endmodule
